@@ rtl/iiel_pkg.sv @@
// Shared types and codes for the indexed insert/erase list unit.
package iiel_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int COMMAND_W = 3;
  localparam int INDEX_W   = 4;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  localparam logic [COMMAND_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [COMMAND_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [COMMAND_W-1:0] CMD_ERASE  = 3'd2;
  localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [COMMAND_W-1:0] CMD_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [COMMAND_W-1:0] command;
    logic [INDEX_W-1:0]   index;
    data_t                value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    data_t               read_value;
  } rsp_t;

  // Broadcast to every cell of the chain for one cycle.
  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

endpackage

@@ rtl/iiel_cell.sv @@
// One storage cell of the list chain, holding a single entry.
module iiel_cell
  import iiel_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int POS   = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] pos,
  input  data_t            value,
  input  data_t            left,
  input  data_t            right,
  output data_t            entry
);

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  data_t entry_next;

  always_comb begin
    entry_next = entry;
    if (ctl.load && (pos == MY_POS)) begin
      entry_next = value;
    end else if (ctl.shift_up && (MY_POS > pos)) begin
      entry_next = left;
    end else if (ctl.shift_down && (MY_POS >= pos)) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ rtl/indexed_insert_erase_list_unit.sv @@
// Top level of the indexed insert/erase list: command decode, count and cell chain.
//
//   channel | direction | handshake             | payload
//   cmd     | in        | cmd_valid / cmd_ready | cmd_t (command, index, value)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_t (status, count, read_value)
//
// One command is taken per cycle while cmd_ready is high; its response is registered and shows in the next cycle.
// Every cell moves at most one place per cycle, so insert and erase shift all affected cells together when accepted.
// cmd_ready is low only while a response waits and rsp_ready is low.
// Reset clears the count and the response valid flag; entries and response data are kept.
module indexed_insert_erase_list_unit
  import iiel_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;
  logic             full;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;
  cell_ctl_t        ctl;
  cell_ctl_t        ctl_dec;
  logic [IDX_W-1:0] pos;
  logic [STATUS_W-1:0] status;
  data_t            rd_mux;
  data_t            rd;
  data_t            entries [DEPTH];
  rsp_t             rsp_next;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign full      = (cnt == FULL_CNT);
  assign idx_ext   = CMP_W'(cmd.index);
  assign cnt_ext   = CMP_W'(cnt);

  always_comb begin
    rd_mux = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (CMP_W'(k) == idx_ext) begin
        rd_mux = entries[k];
      end
    end
  end

  always_comb begin
    ctl_dec  = '0;
    pos      = IDX_W'(idx_ext);
    status   = ST_DONE;
    rd       = '0;
    cnt_next = cnt;
    case (cmd.command)
      CMD_APPEND: begin
        pos = IDX_W'(cnt);
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl_dec.load = 1'b1;
          cnt_next     = cnt + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (idx_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          ctl_dec.load     = 1'b1;
          ctl_dec.shift_up = 1'b1;
          cnt_next         = cnt + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (idx_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          ctl_dec.shift_down = 1'b1;
          cnt_next           = cnt - 1'b1;
        end
      end
      CMD_CLEAR: begin
        cnt_next = '0;
      end
      CMD_READ: begin
        if (idx_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          rd = rd_mux;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl = accept ? ctl_dec : '0;

  // Each cell takes from its lower neighbor on insert and its upper one on erase.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    data_t left_in;
    data_t right_in;
    if (k == 0) begin : g_first
      assign left_in = entries[k];
    end else begin : g_mid_l
      assign left_in = entries[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_in = entries[k];
    end else begin : g_mid_r
      assign right_in = entries[k+1];
    end
    iiel_cell #(
      .IDX_W (IDX_W),
      .POS   (k)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (pos),
      .value (cmd.value),
      .left  (left_in),
      .right (right_in),
      .entry (entries[k])
    );
  end

  always_comb begin
    rsp_next.status     = status;
    rsp_next.count      = COUNT_W'(cnt_next);
    rsp_next.read_value = rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_CNT)
    else $error("entry count above capacity");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.count == COUNT_W'(cnt)))
    else $error("response count differs from count register");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_FULL)) |-> full)
    else $error("full status reported on a list that is not full");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.command != CMD_READ)) |=> (rsp.read_value == '0))
    else $error("read value nonzero for a command other than read");
`endif

endmodule

@@ tb/indexed_insert_erase_list_unit_tb.sv @@
// Self-checking testbench for the indexed insert/erase list unit.
module indexed_insert_erase_list_unit_tb;
  import iiel_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam int INDEX_MAX = (1 << INDEX_W) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1600;

  // Command codes the block decodes as no operation.
  localparam logic [COMMAND_W-1:0] CMD_UNUSED_A = 3'd5;
  localparam logic [COMMAND_W-1:0] CMD_UNUSED_B = 3'd6;
  localparam logic [COMMAND_W-1:0] CMD_UNUSED_C = 3'd7;

  localparam data_t DATA_MAX = 32'sh7fff_ffff;
  localparam data_t DATA_MIN = 32'sh8000_0000;
  localparam data_t DATA_ONES = 32'shffff_ffff;
  localparam data_t DATA_ZERO = 32'sh0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Shadow copy of the list contents and length.
  data_t list_entries [LIST_DEPTH];
  logic [COUNT_W-1:0] list_count = '0;

  rsp_t expected_responses [$];
  int failures = 0;
  int idle_cycles = 0;
  bit steady_flow = 1'b0;

  indexed_insert_erase_list_unit #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic rsp_t predict_list_response(cmd_t c);
    rsp_t r;
    int k;
    r.status = ST_DONE;
    r.read_value = '0;
    case (c.command)
      CMD_APPEND: begin
        if (int'(list_count) >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_entries[list_count] = c.value;
          list_count = list_count + 1'b1;
        end
      end
      CMD_INSERT: begin
        // A full list is reported even when the index is also bad.
        if (int'(list_count) >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (COUNT_W'(c.index) > list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = int'(list_count); k > int'(c.index); k--) begin
            list_entries[k] = list_entries[k-1];
          end
          list_entries[c.index] = c.value;
          list_count = list_count + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (COUNT_W'(c.index) >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = int'(c.index); k + 1 < int'(list_count); k++) begin
            list_entries[k] = list_entries[k+1];
          end
          list_count = list_count - 1'b1;
        end
      end
      CMD_CLEAR: begin
        list_count = '0;
      end
      CMD_READ: begin
        if (COUNT_W'(c.index) >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_entries[c.index];
        end
      end
      default: begin
      end
    endcase
    r.count = list_count;
    return r;
  endfunction

  function automatic cmd_t make_command(logic [COMMAND_W-1:0] op, logic [INDEX_W-1:0] idx,
                                        data_t val);
    cmd_t c;
    c.command = op;
    c.index = idx;
    c.value = val;
    return c;
  endfunction

  function automatic int pick_idle_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Valid is left high after acceptance; the next call decides whether it drops.
  task automatic send_list_command(input cmd_t c);
    int gap;
    gap = pick_idle_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    expected_responses.insert(expected_responses.size(), predict_list_response(c));
  endtask

  task automatic wait_responses_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (expected_responses.size() > 0);
  endtask

  function automatic cmd_t random_list_command(bit grow);
    cmd_t c;
    int r;
    int pick;
    r = $urandom_range(99);
    if (grow) begin
      pick = (r < 35) ? 0 : (r < 65) ? 1 : (r < 75) ? 2 : (r < 95) ? 4 : (r < 96) ? 3 : 5;
    end else begin
      pick = (r < 10) ? 0 : (r < 20) ? 1 : (r < 55) ? 2 : (r < 90) ? 4 : (r < 92) ? 3 : 5;
    end
    case (pick)
      0: c.command = CMD_APPEND;
      1: c.command = CMD_INSERT;
      2: c.command = CMD_ERASE;
      3: c.command = CMD_CLEAR;
      4: c.command = CMD_READ;
      default: c.command = COMMAND_W'($urandom_range(CMD_UNUSED_C, CMD_UNUSED_A));
    endcase
    c.index = INDEX_W'($urandom_range(INDEX_MAX));
    // Most indexes land inside the list so that shifts actually happen.
    if ($urandom_range(99) < 85) begin
      if (c.command == CMD_INSERT) begin
        c.index = INDEX_W'($urandom_range((int'(list_count) > INDEX_MAX) ? INDEX_MAX :
                                          int'(list_count)));
      end else if ((c.command == CMD_ERASE || c.command == CMD_READ) &&
                   int'(list_count) > 0) begin
        c.index = INDEX_W'($urandom_range(int'(list_count) - 1));
      end
    end
    case ($urandom_range(39))
      0: c.value = DATA_MAX;
      1: c.value = DATA_MIN;
      2: c.value = DATA_ZERO;
      3: c.value = DATA_ONES;
      default: c.value = data_t'($urandom());
    endcase
    return c;
  endfunction

  task automatic test_basic_commands();
    send_list_command(make_command(CMD_READ, 4'd0, DATA_ZERO));
    send_list_command(make_command(CMD_ERASE, 4'd0, DATA_ZERO));
    send_list_command(make_command(CMD_APPEND, 4'd0, DATA_MAX));
    send_list_command(make_command(CMD_APPEND, 4'd15, DATA_MIN));
    send_list_command(make_command(CMD_APPEND, 4'd0, DATA_ZERO));
    send_list_command(make_command(CMD_APPEND, 4'd0, DATA_ONES));
    send_list_command(make_command(CMD_INSERT, 4'd0, 32'sh5a5a_5a5a));
    // Inserting at the current length behaves as an append.
    send_list_command(make_command(CMD_INSERT, 4'd5, 32'sha5a5_a5a5));
    send_list_command(make_command(CMD_INSERT, 4'd15, DATA_MAX));
    send_list_command(make_command(CMD_READ, 4'd0, DATA_ZERO));
    send_list_command(make_command(CMD_READ, 4'd5, DATA_ZERO));
    send_list_command(make_command(CMD_READ, 4'd6, DATA_ZERO));
    send_list_command(make_command(CMD_READ, 4'd15, DATA_ONES));
    send_list_command(make_command(CMD_ERASE, 4'd0, DATA_ZERO));
    send_list_command(make_command(CMD_ERASE, 4'd4, DATA_ZERO));
    send_list_command(make_command(CMD_ERASE, 4'd15, DATA_ZERO));
    send_list_command(make_command(CMD_UNUSED_A, 4'd15, DATA_MAX));
    send_list_command(make_command(CMD_UNUSED_B, 4'd0, DATA_MIN));
    send_list_command(make_command(CMD_UNUSED_C, 4'd3, DATA_ONES));
    send_list_command(make_command(CMD_INSERT, 4'd2, -32'sd5));
    send_list_command(make_command(CMD_READ, 4'd2, DATA_ZERO));
    send_list_command(make_command(CMD_CLEAR, 4'd9, DATA_MAX));
    send_list_command(make_command(CMD_READ, 4'd0, DATA_ZERO));
    send_list_command(make_command(CMD_APPEND, 4'd0, 32'sd1));
    send_list_command(make_command(CMD_READ, 4'd0, DATA_ZERO));
  endtask

  task automatic test_full_list();
    int n;
    send_list_command(make_command(CMD_CLEAR, 4'd0, DATA_ZERO));
    for (n = 0; n < LIST_DEPTH; n++) begin
      send_list_command(make_command(CMD_APPEND, INDEX_W'($urandom_range(INDEX_MAX)),
                                     data_t'($urandom())));
    end
    send_list_command(make_command(CMD_APPEND, 4'd0, DATA_MAX));
    send_list_command(make_command(CMD_INSERT, 4'd15, DATA_MIN));
    send_list_command(make_command(CMD_INSERT, 4'd0, DATA_ONES));
    send_list_command(make_command(CMD_READ, 4'd15, DATA_ZERO));
    send_list_command(make_command(CMD_ERASE, 4'd7, DATA_ZERO));
    send_list_command(make_command(CMD_INSERT, 4'd15, DATA_MIN));
    send_list_command(make_command(CMD_READ, 4'd15, DATA_ZERO));
    send_list_command(make_command(CMD_READ, 4'd7, DATA_ZERO));
    send_list_command(make_command(CMD_ERASE, 4'd15, DATA_ZERO));
    send_list_command(make_command(CMD_ERASE, 4'd0, DATA_ZERO));
    send_list_command(make_command(CMD_CLEAR, 4'd0, DATA_ZERO));
  endtask

  task automatic test_random_traffic();
    int n;
    bit grow;
    grow = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) grow = (n % 200 == 0);
      if (n % 64 == 0) steady_flow = ($urandom_range(3) == 0);
      // Let the sender go quiet until the list has answered everything.
      if (n % 400 == 399) wait_responses_drained();
      send_list_command(random_list_command(grow));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        stall_left = pick_idle_gap();
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_response
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_responses.size() == 0) begin
        $error("response transaction with no command outstanding: %p", rsp);
        failures++;
      end else begin
        want = expected_responses.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          failures++;
        end
        if (rsp.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, rsp.count);
          failures++;
        end
        if (rsp.read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value, rsp.read_value);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_commands();
    wait_responses_drained();
    test_full_list();
    wait_responses_drained();
    test_random_traffic();
    wait_responses_drained();
    repeat (4) @(posedge clk);
    if (failures == 0 && expected_responses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
